### design/autoranging_echo_to_duty_level_macros.svh
// Assertion macros for the checker file of this block.
`ifndef AUTORANGING_ECHO_TO_DUTY_LEVEL_MACROS_SVH
`define AUTORANGING_ECHO_TO_DUTY_LEVEL_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AEDL_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("aedl check failed");

// Next-cycle implication, disabled while reset is asserted.
`define AEDL_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("aedl check failed");

`endif

### design/aedl_pkg.sv
package aedl_pkg;

    localparam int READINGS  = 4;
    localparam int RD_W      = 16;
    localparam int SUM_W     = 18;
    localparam int GOOD_W    = 3;
    localparam int REM_W     = 20;
    localparam int DVS_W     = 21;
    localparam int CNT_W     = 4;
    localparam int AVG_STEPS = 16;
    localparam int LVL_STEPS = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [RD_W-1:0] TIMEOUT_TICKS = 16'hFFFF;
    localparam logic [3:0]      LEVEL_STEPS   = 4'd10;
    localparam logic [3:0]      LEVEL_TOP     = 4'd9;

    localparam logic [CFG_IDX_W-1:0] CFG_INIT_SAMPLES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MARGIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECAL_PERIOD = 2'd2;

    typedef struct packed {
        logic [15:0] reading_a;
        logic [15:0] reading_b;
        logic [15:0] reading_c;
        logic [15:0] reading_d;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  duty;
        logic [3:0]  level;
        logic        measured;
        logic [15:0] average_ticks;
    } t_out_item;

    function automatic logic [7:0] duty_of(input logic [3:0] lvl);
        logic [7:0] d;
        case (lvl)
            4'd0:    d = 8'd13;
            4'd1:    d = 8'd38;
            4'd2:    d = 8'd64;
            4'd3:    d = 8'd89;
            4'd4:    d = 8'd115;
            4'd5:    d = 8'd140;
            4'd6:    d = 8'd166;
            4'd7:    d = 8'd191;
            4'd8:    d = 8'd217;
            4'd9:    d = 8'd242;
            default: d = 8'd13;
        endcase
        return d;
    endfunction

endpackage

### design/autoranging_echo_to_duty_level.sv
// Autoranging echo-time to duty level converter.
// Input channel (i_in_valid, i_in_data, o_in_stall): one beat carries four
// echo readings; a beat is taken when valid is high and stall is low.
// Output channel (o_out_valid, o_out_data, i_out_stall): one result beat per
// input beat, held in an output register until the receiver lowers stall.
// Configuration channel (i_cfg_valid, i_cfg_index, i_cfg_data, o_cfg_ready)
// writes init_samples, range_margin and recal_period; ready is always high.
// Each item runs through accumulation of its four readings, sixteen steps of
// a restoring divider for the average, range update in S_UPD, S_FIX and
// S_PREP and, unless the range is too narrow, four steps of the same divider
// for the level; no new beat is taken until the result is loaded. A round
// with no valid reading goes from accumulation straight to the final state.
// While an item is in work the input stall is high. A new item may enter
// while the previous result still waits; if it finishes before the receiver
// takes that result, it waits in the final state.
// Reset clears the calibrated range and the counters, sets the held duty to
// the level-0 duty, clears the output valid and restores the register defaults.
module autoranging_echo_to_duty_level (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  aedl_pkg::t_in_item                  i_in_data,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output aedl_pkg::t_out_item                 o_out_data,
    input  logic                                i_out_stall,
    input  logic                                i_cfg_valid,
    input  logic [aedl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [15:0]                         i_cfg_data,
    output logic                                o_cfg_ready
);
    import aedl_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUM  = 3'd1;
    localparam logic [2:0] S_DAVG = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_FIX  = 3'd4;
    localparam logic [2:0] S_PREP = 3'd5;
    localparam logic [2:0] S_DLVL = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [RD_W-1:0]   r_rd [READINGS];
    logic [RD_W-1:0]   n_rd [READINGS];
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [GOOD_W-1:0] r_good, n_good;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [DVS_W-1:0]  r_dvs, n_dvs;
    logic [15:0]       r_quo, n_quo;
    logic [15:0]       r_avg, n_avg;
    logic [3:0]        r_level, n_level;
    logic              r_measured, n_measured;
    logic [15:0]       r_lo, n_lo;
    logic [15:0]       r_hi, n_hi;
    logic [15:0]       r_round, n_round;
    logic [15:0]       r_samples, n_samples;
    logic [7:0]        r_held, n_held;
    logic [15:0]       r_init, n_init;
    logic [15:0]       r_margin, n_margin;
    logic [15:0]       r_recal, n_recal;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic              w_ge;
    logic [REM_W-1:0]  w_diff;
    logic              w_plain;
    logic              w_recal;
    logic [16:0]       w_avg17;
    logic [16:0]       w_span17;
    logic [15:0]       w_clip;
    logic [15:0]       w_pos;
    logic [3:0]        w_q;

    always_comb begin
        w_ge     = {1'b0, r_rem} >= r_dvs;
        w_diff   = r_rem - r_dvs[REM_W-1:0];
        w_plain  = (r_samples < r_init) || (r_round >= r_recal);
        w_recal  = r_round >= r_recal;
        w_avg17  = {1'b0, r_quo};
        w_span17 = {1'b0, r_hi} - {1'b0, r_lo} + 17'd1;
        if (r_avg < r_lo) begin
            w_clip = r_lo;
        end else if (r_avg > r_hi) begin
            w_clip = r_hi;
        end else begin
            w_clip = r_avg;
        end
        w_pos = w_clip - r_lo;
        w_q   = '0;

        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rd        = r_rd;
        n_sum       = r_sum;
        n_good      = r_good;
        n_rem       = r_rem;
        n_dvs       = r_dvs;
        n_quo       = r_quo;
        n_avg       = r_avg;
        n_level     = r_level;
        n_measured  = r_measured;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_round     = r_round;
        n_samples   = r_samples;
        n_held      = r_held;
        n_init      = r_init;
        n_margin    = r_margin;
        n_recal     = r_recal;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_INIT_SAMPLES: n_init   = i_cfg_data;
                CFG_RANGE_MARGIN: n_margin = i_cfg_data;
                CFG_RECAL_PERIOD: n_recal  = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_rd[0] = i_in_data.reading_a;
                    n_rd[1] = i_in_data.reading_b;
                    n_rd[2] = i_in_data.reading_c;
                    n_rd[3] = i_in_data.reading_d;
                    n_sum   = '0;
                    n_good  = '0;
                    n_cnt   = CNT_W'(READINGS - 1);
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (r_rd[0] != TIMEOUT_TICKS) begin
                    n_sum  = r_sum + SUM_W'(r_rd[0]);
                    n_good = r_good + GOOD_W'(1);
                end
                for (int i = 0; i < READINGS - 1; i++) begin
                    n_rd[i] = r_rd[i+1];
                end
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_measured = n_good != '0;
                    if (n_good == '0) begin
                        n_round = r_round + 16'd1;
                        n_state = S_DONE;
                    end else begin
                        n_rem   = REM_W'(n_sum);
                        n_dvs   = DVS_W'({n_good, 15'b0});
                        n_quo   = '0;
                        n_cnt   = CNT_W'(AVG_STEPS - 1);
                        n_state = S_DAVG;
                    end
                end
            end
            S_DAVG, S_DLVL: begin
                if (w_ge) begin
                    n_rem = w_diff;
                end
                n_quo = {r_quo[14:0], w_ge};
                n_dvs = r_dvs >> 1;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    if (r_state == S_DAVG) begin
                        n_state = S_UPD;
                    end else begin
                        w_q     = (n_quo[3:0] > LEVEL_TOP) ? LEVEL_TOP : n_quo[3:0];
                        n_level = LEVEL_TOP - w_q;
                        n_state = S_DONE;
                    end
                end
            end
            S_UPD: begin
                n_avg = r_quo;
                if (w_plain) begin
                    if (r_quo < r_lo) begin
                        n_lo = r_quo;
                    end
                    if (r_quo > r_hi) begin
                        n_hi = r_quo;
                    end
                    n_samples = r_samples + 16'd1;
                    if (w_recal) begin
                        n_samples = '0;
                        n_lo      = 16'hFFFF;
                        n_hi      = '0;
                    end
                end else begin
                    if (w_avg17 + {1'b0, r_margin} < {1'b0, r_lo}) begin
                        n_lo = r_quo;
                    end
                    if (w_avg17 > {1'b0, r_hi} + {1'b0, r_margin}) begin
                        n_hi = r_quo;
                    end
                end
                n_round = w_recal ? 16'd1 : r_round + 16'd1;
                n_state = S_FIX;
            end
            S_FIX: begin
                if (r_hi <= r_lo) begin
                    n_hi = r_lo + 16'd1;
                end
                n_state = S_PREP;
            end
            S_PREP: begin
                if ({1'b0, r_hi} <= {1'b0, r_lo} + 17'd1) begin
                    n_level = '0;
                    n_state = S_DONE;
                end else begin
                    n_rem   = REM_W'(w_pos) * REM_W'(LEVEL_STEPS);
                    n_dvs   = DVS_W'({w_span17, 3'b0});
                    n_quo   = '0;
                    n_cnt   = CNT_W'(LVL_STEPS - 1);
                    n_state = S_DLVL;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out.measured = r_measured;
                    if (r_measured) begin
                        n_held              = duty_of(r_level);
                        n_out.duty          = duty_of(r_level);
                        n_out.level         = r_level;
                        n_out.average_ticks = r_avg;
                    end else begin
                        n_out.duty          = r_held;
                        n_out.level         = '0;
                        n_out.average_ticks = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_lo        <= 16'hFFFF;
            r_hi        <= '0;
            r_round     <= '0;
            r_samples   <= '0;
            r_held      <= duty_of('0);
            r_init      <= 16'd16;
            r_margin    <= 16'd1;
            r_recal     <= 16'd400;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_lo        <= n_lo;
            r_hi        <= n_hi;
            r_round     <= n_round;
            r_samples   <= n_samples;
            r_held      <= n_held;
            r_init      <= n_init;
            r_margin    <= n_margin;
            r_recal     <= n_recal;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_rd       <= n_rd;
        r_sum      <= n_sum;
        r_good     <= n_good;
        r_rem      <= n_rem;
        r_dvs      <= n_dvs;
        r_quo      <= n_quo;
        r_avg      <= n_avg;
        r_level    <= n_level;
        r_measured <= n_measured;
        r_out      <= n_out;
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

### design/aedl_checker.sv
`include "autoranging_echo_to_duty_level_macros.svh"

module aedl_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input aedl_pkg::t_out_item                 o_out_data,
    input logic                                i_out_stall
);
    import aedl_pkg::*;

    `AEDL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))
    `AEDL_ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `AEDL_ASSERT_IMPLY(a_level_range, i_clk, i_rst_n, o_out_valid, o_out_data.level <= LEVEL_TOP)
    `AEDL_ASSERT_IMPLY(a_no_measure, i_clk, i_rst_n, o_out_valid && !o_out_data.measured, o_out_data.level == 4'd0 && o_out_data.average_ticks == 16'd0)
    `AEDL_ASSERT_IMPLY(a_duty_table, i_clk, i_rst_n, o_out_valid && o_out_data.measured, o_out_data.duty == duty_of(o_out_data.level))

endmodule

bind autoranging_echo_to_duty_level aedl_checker u_aedl_checker (.*);

### tb/tb.sv
`timescale 1ns / 1ps

import aedl_pkg::*;

class duty_scoreboard;
    logic [15:0] init_samples;
    logic [15:0] range_margin;
    logic [15:0] recal_period;
    logic [15:0] range_lo;
    logic [15:0] range_hi;
    logic [15:0] rounds;
    logic [15:0] samples;
    logic [7:0]  held_duty;
    logic [7:0]  duty_steps [10] = '{8'd13, 8'd38, 8'd64, 8'd89, 8'd115,
                                     8'd140, 8'd166, 8'd191, 8'd217, 8'd242};
    t_out_item   pending_results [$];
    int          errors;
    int          checked;
    int          measured_rounds;
    int          blind_rounds;
    int          range_clears;
    int          reg_writes;

    function new();
        init_samples    = 16'd16;
        range_margin    = 16'd1;
        recal_period    = 16'd400;
        range_lo        = 16'hFFFF;
        range_hi        = 16'd0;
        rounds          = 16'd0;
        samples         = 16'd0;
        held_duty       = duty_steps[0];
        errors          = 0;
        checked         = 0;
        measured_rounds = 0;
        blind_rounds    = 0;
        range_clears    = 0;
        reg_writes      = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        reg_writes++;
        case (idx)
            CFG_INIT_SAMPLES: init_samples = val;
            CFG_RANGE_MARGIN: range_margin = val;
            CFG_RECAL_PERIOD: recal_period = val;
            default: ;
        endcase
    endfunction

    // Works out the result beat of one accepted input beat.
    function void note_round(t_in_item it);
        logic [15:0] r [4];
        int unsigned good;
        int unsigned total;
        int unsigned avg;
        int unsigned lvl;
        int unsigned lo;
        int unsigned hi;
        int unsigned clipped;
        int unsigned base;
        t_out_item   want;
        r[0] = it.reading_a;
        r[1] = it.reading_b;
        r[2] = it.reading_c;
        r[3] = it.reading_d;
        good = 0;
        total = 0;
        avg = 0;
        lvl = 0;
        foreach (r[k]) begin
            if (r[k] != TIMEOUT_TICKS) begin
                total += r[k];
                good++;
            end
        end
        if (good != 0) begin
            measured_rounds++;
            avg = total / good;
            lo = range_lo;
            hi = range_hi;
            if (samples < init_samples || rounds >= recal_period) begin
                if (avg < lo) range_lo = avg[15:0];
                if (avg > hi) range_hi = avg[15:0];
                samples = samples + 16'd1;
                if (rounds >= recal_period) begin
                    rounds = 16'd0;
                    samples = 16'd0;
                    range_lo = 16'hFFFF;
                    range_hi = 16'd0;
                    range_clears++;
                end
            end else begin
                if (avg + range_margin < lo) range_lo = avg[15:0];
                if (avg > hi + range_margin) range_hi = avg[15:0];
            end
            if (range_hi <= range_lo) range_hi = range_lo + 16'd1;
            lo = range_lo;
            hi = range_hi;
            if (hi <= lo + 1) begin
                lvl = 0;
            end else begin
                clipped = avg;
                if (clipped < lo) clipped = lo;
                if (clipped > hi) clipped = hi;
                base = ((clipped - lo) * LEVEL_STEPS) / ((hi - lo) + 1);
                if (base > LEVEL_TOP) base = LEVEL_TOP;
                lvl = LEVEL_TOP - base;
            end
            held_duty = duty_steps[lvl];
        end else begin
            blind_rounds++;
        end
        rounds = rounds + 16'd1;
        want.duty          = held_duty;
        want.level         = lvl[3:0];
        want.measured      = (good != 0);
        want.average_ticks = avg[15:0];
        pending_results.push_back(want);
    endfunction

    task report_mismatch(string what, int unsigned got_v, int unsigned want_v);
        errors++;
        if (errors <= 40) $display("mismatch: %s got %0d expected %0d", what, got_v, want_v);
    endtask

    task check_result(t_out_item got);
        t_out_item want;
        if (pending_results.size() == 0) begin
            report_mismatch("unexpected result beat, duty", got.duty, 0);
            return;
        end
        want = pending_results.pop_front();
        checked++;
        if (got.duty !== want.duty) report_mismatch("duty", got.duty, want.duty);
        if (got.level !== want.level) report_mismatch("level", got.level, want.level);
        if (got.measured !== want.measured)
            report_mismatch("measured", got.measured, want.measured);
        if (got.average_ticks !== want.average_ticks)
            report_mismatch("average_ticks", got.average_ticks, want.average_ticks);
    endtask
endclass

module tb;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_AFTER    = 180;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_CYCLES  = 60;
    localparam int PHASES        = 6;
    localparam int PHASE_ROUNDS  = 100;

    logic                 i_clk;
    logic                 rst_n;
    logic                 in_valid;
    t_in_item             in_data;
    logic                 in_stall;
    logic                 out_valid;
    t_out_item            out_data;
    logic                 out_stall;
    logic                 cfg_valid;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;
    logic                 cfg_ready;

    duty_scoreboard sb = new();
    int  cycle_count = 0;
    int  sent_rounds = 0;
    bit  quiet = 1'b0;
    bit  hold_done = 1'b0;
    int  center;
    int  cmin;
    int  cmax;
    int  jit;

    autoranging_echo_to_duty_level uut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_cfg_ready (cfg_ready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb: errors");
            $finish;
        end
    end

    function automatic t_in_item rd4(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                     logic [15:0] d);
        t_in_item it;
        it.reading_a = a;
        it.reading_b = b;
        it.reading_c = c;
        it.reading_d = d;
        return it;
    endfunction

    function automatic logic [15:0] near_center();
        int v;
        if ($urandom_range(0, 9) == 0) return TIMEOUT_TICKS;
        v = center + int'($urandom_range(0, 2 * jit)) - jit;
        if (v < 0) v = 0;
        if (v > int'(TIMEOUT_TICKS) - 1) v = int'(TIMEOUT_TICKS) - 1;
        return v[15:0];
    endfunction

    // Most rounds follow a slowly moving target; the rest are blind or pure noise.
    function automatic t_in_item next_round();
        int pick;
        int step;
        pick = $urandom_range(0, 99);
        if (pick < 8) return rd4(TIMEOUT_TICKS, TIMEOUT_TICKS, TIMEOUT_TICKS, TIMEOUT_TICKS);
        if (pick < 18)
            return rd4(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        step = (cmax - cmin) / 10 + 1;
        center = center + int'($urandom_range(0, 2 * step)) - step;
        if (center < cmin) center = cmin;
        if (center > cmax) center = cmax;
        return rd4(near_center(), near_center(), near_center(), near_center());
    endfunction

    task automatic send_round(input t_in_item it);
        int gap;
        int pick;
        gap = 0;
        if (!quiet) begin
            pick = $urandom_range(0, 99);
            if (pick >= 90) gap = $urandom_range(10, 50);
            else if (pick >= 50) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge i_clk); while (in_stall);
        sb.note_round(it);
        sent_rounds++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [15:0] init_v, input logic [15:0] margin_v,
                              input logic [15:0] recal_v, input bit poke_spare);
        logic [CFG_IDX_W-1:0] idx_q [$];
        logic [15:0]          val_q [$];
        idx_q = '{CFG_INIT_SAMPLES, CFG_RANGE_MARGIN, CFG_RECAL_PERIOD};
        val_q = '{init_v, margin_v, recal_v};
        if (poke_spare) begin
            idx_q.push_front(CFG_SPARE);
            val_q.push_front(16'($urandom));
        end
        foreach (idx_q[k]) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_q[k];
            cfg_data <= val_q[k];
            do @(posedge i_clk); while (!cfg_ready);
            sb.set_register(idx_q[k], val_q[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    // The receiver takes and checks result beats, stalling in runs of random length and once in a long hold-off.
    initial begin : result_side
        int  run_left;
        bit  run_stall;
        int  pick;
        run_left = 0;
        run_stall = 1'b0;
        out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
            if (run_left == 0) begin
                pick = $urandom_range(0, 99);
                if (!hold_done && sent_rounds >= HOLD_AFTER) begin
                    hold_done = 1'b1;
                    run_stall = 1'b1;
                    run_left = HOLD_CYCLES;
                end else if (quiet) begin
                    run_stall = 1'b0;
                    run_left = 1;
                end else if (pick < 50) begin
                    run_stall = 1'b0;
                    run_left = $urandom_range(1, 8);
                end else if (pick < 94) begin
                    run_stall = 1'b1;
                    run_left = $urandom_range(1, 3);
                end else begin
                    run_stall = 1'b1;
                    run_left = $urandom_range(20, 60);
                end
            end
            out_stall <= run_stall;
            run_left--;
        end
    end

    initial begin : stimulus
        logic [15:0] init_v;
        logic [15:0] margin_v;
        logic [15:0] recal_v;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Register defaults: timeouts, extremes, partial and steady rounds, all within the calibration samples.
        send_round(rd4(TIMEOUT_TICKS, TIMEOUT_TICKS, TIMEOUT_TICKS, TIMEOUT_TICKS));
        send_round(rd4(16'd0, 16'd0, 16'd0, 16'd0));
        send_round(rd4(16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE));
        send_round(rd4(16'd1000, TIMEOUT_TICKS, TIMEOUT_TICKS, TIMEOUT_TICKS));
        send_round(rd4(16'd0, 16'hFFFE, 16'd1, TIMEOUT_TICKS));
        send_round(rd4(16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFD));
        send_round(rd4(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA));
        send_round(rd4(TIMEOUT_TICKS, TIMEOUT_TICKS, TIMEOUT_TICKS, 16'd7));
        send_round(rd4(16'd500, 16'd510, 16'd490, 16'd500));
        send_round(rd4(16'd2000, 16'd2010, TIMEOUT_TICKS, 16'd1990));
        send_round(rd4(16'd1200, 16'd1200, 16'd1201, 16'd1199));
        send_round(rd4(16'd800, TIMEOUT_TICKS, 16'd800, 16'd801));
        send_round(rd4(TIMEOUT_TICKS, TIMEOUT_TICKS, TIMEOUT_TICKS, TIMEOUT_TICKS));
        send_round(rd4(16'd1500, 16'd1500, 16'd1500, 16'd1500));

        // Zero recalibration period: every measured round clears the range.
        settle();
        write_regs(16'd0, 16'd0, 16'd0, 1'b1);
        send_round(rd4(16'd300, 16'd300, 16'd300, 16'd300));
        send_round(rd4(16'd9000, 16'd100, TIMEOUT_TICKS, 16'd50));
        send_round(rd4(TIMEOUT_TICKS, TIMEOUT_TICKS, TIMEOUT_TICKS, TIMEOUT_TICKS));
        send_round(rd4(16'd0, 16'd0, 16'd0, 16'd1));

        // Widest margin: after two calibration rounds the range never widens.
        settle();
        write_regs(16'd2, 16'hFFFF, 16'hFFFF, 1'b0);
        send_round(rd4(16'd100, 16'd100, 16'd100, 16'd100));
        send_round(rd4(16'd3000, 16'd3000, 16'd3000, 16'd3000));
        send_round(rd4(16'd2000, 16'd2000, 16'd2000, 16'd2000));
        send_round(rd4(16'd50, 16'd50, TIMEOUT_TICKS, 16'd50));
        send_round(rd4(16'd4000, 16'd4000, 16'd4000, 16'd4000));
        send_round(rd4(16'hFFFE, TIMEOUT_TICKS, TIMEOUT_TICKS, TIMEOUT_TICKS));

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin init_v = 16'd16; margin_v = 16'd1; recal_v = 16'd400; end
                1: begin init_v = 16'd4; margin_v = 16'd10; recal_v = 16'd30; end
                2: begin init_v = 16'd0; margin_v = 16'd0; recal_v = 16'd1; end
                3: begin init_v = 16'hFFFF; margin_v = 16'hFFFF; recal_v = 16'hFFFF; end
                default: begin
                    init_v = 16'($urandom_range(0, 40));
                    margin_v = 16'($urandom_range(0, 300));
                    recal_v = 16'($urandom_range(1, 150));
                end
            endcase
            settle();
            write_regs(init_v, margin_v, recal_v, p == PHASES - 1);
            quiet = (p == 0);
            if ($urandom_range(0, 1) == 1) begin
                cmin = 200;
                cmax = 4000;
            end else begin
                cmin = 0;
                cmax = int'(TIMEOUT_TICKS) - 1;
            end
            center = cmin + (cmax - cmin) / 2;
            jit = (cmax - cmin) / 64 + 1;
            repeat (PHASE_ROUNDS) send_round(next_round());
        end

        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("summary: %0d rounds checked, %0d measured, %0d blind, %0d range clears",
                 sb.checked, sb.measured_rounds, sb.blind_rounds, sb.range_clears);
        $display("summary: %0d register writes, receiver hold-off of %0d cycles %s",
                 sb.reg_writes, HOLD_CYCLES, hold_done ? "done" : "missed");
        if (sb.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
